// ----- sv/dpca_pkg.sv -----
// Shared types, constants and table functions for the dew point condensation alarm.
package dpca_pkg;

  // Field and register widths fixed by the interface
  localparam int RH_BITS  = 14;
  localparam int B_BITS   = 16;
  localparam int C_BITS   = 13;
  localparam int MUL_BITS = 17;

  // Register reset values and fixed constants of the Magnus formula
  localparam logic [B_BITS-1:0]   B_RESET  = 16'd18094;
  localparam logic [C_BITS-1:0]   C_RESET  = 13'd3896;
  localparam logic [MUL_BITS-1:0] LN2_Q16  = 17'd45426;
  localparam int                  FULL_RH  = 10000;

  // Configuration register indexes
  localparam logic CFG_MAGNUS_B = 1'b0;
  localparam logic CFG_MAGNUS_C = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG_MUL,
    ST_LN_MUL,
    ST_FR_MUL,
    ST_FR_DIV,
    ST_DP_MUL,
    ST_DP_DIV,
    ST_OUT
  } state_t;

  // Operation of the shared multiply/divide unit
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_t;

  // Command from the sequencer to the shared unit
  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_ctl_t;

  // Fraction part of log2(1 + k/2^lbits) in Q16, by repeated squaring.
  // The entry past the end of the table is exactly one.
  function automatic logic [16:0] log_entry(input int unsigned k, input int unsigned lbits);
    logic [63:0] m;
    logic [16:0] r;
    r = '0;
    if (k >= (32'd1 << lbits)) begin
      r = 17'h10000;
    end else begin
      m = (64'd1 << 30) + (64'(k) << (30 - lbits));
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r = r | 17'd1;
          m = m >> 1;
        end
      end
    end
    return r;
  endfunction

  // log2 of a constant in Q16, matching the table interpolation of the datapath
  function automatic logic [31:0] log2_q16_const(input int unsigned x, input int unsigned lbits);
    int unsigned e;
    int unsigned fs;
    logic [63:0] frac;
    logic [63:0] rem;
    logic [63:0] k;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [63:0] d;
    e  = 0;
    fs = 31 - lbits;
    while (e < 31 && (x >> (e + 1)) != 0) begin
      e++;
    end
    frac = (64'(x) << (31 - e)) - (64'd1 << 31);
    k    = frac >> fs;
    rem  = frac & ((64'd1 << fs) - 64'd1);
    t0   = log_entry(32'(k), lbits);
    t1   = log_entry(32'(k) + 32'd1, lbits);
    d    = (t1 > t0) ? 64'(t1 - t0) : 64'd0;
    return 32'((64'(e) << 16) + 64'(t0) + ((d * rem) >> fs));
  endfunction

endpackage

// ----- sv/dew_point_condensation_alarm_top.sv -----
// Top level of the dew point condensation alarm: sequencer, state and stream ports.
//
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser: s_tdata carries the
// humidity, housing and cold-finger temperatures, s_tuser the sensor read flag.
// Each item gives exactly one result item on m_tvalid/m_tready/m_tdata/m_tuser.
// A good read with non-zero humidity runs the Magnus dew point through four
// bit-serial multiplies and two restoring divides on one shared unit, which works
// one bit per cycle. When gamma reaches b the last multiply and divide are
// skipped. A failed read or zero humidity goes straight to the output step.
// One item is worked on at a time; s_tready is high only while the sequencer
// is idle. The result sits in an output register, so the next item can be
// accepted while the receiver stalls; the sequencer holds its finished result
// until that register is free. Configuration writes on cfg_we/cfg_addr/cfg_wdata
// take effect at once; the user must make them only while the block is idle,
// which the block itself does not enforce.
// Reset (rst, synchronous) restores the Magnus coefficients, clears the stored
// dew point to zero, marks the finger as not above the dew point and empties
// the output register.
module dew_point_condensation_alarm_top
  import dpca_pkg::*;
#(
  parameter int TEMP_BITS      = 12,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // rel_humidity, housing_temp, finger_temp
  input  logic [((RH_BITS+2*TEMP_BITS+7)/8)*8-1:0] s_tdata,
  // read_ok
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // dew_point, below_event, above_event, above_flag
  output logic [((TEMP_BITS+3+7)/8)*8-1:0]       m_tdata,
  // sample_valid, dry_flag
  output logic [1:0]                             m_tuser,
  input  logic                                   cfg_we,
  input  logic                                   cfg_addr,
  input  logic [B_BITS-1:0]                      cfg_wdata
);

  localparam int TB    = TEMP_BITS;
  localparam int OUT_W = ((TB + 3 + 7) / 8) * 8;
  localparam int NW    = TB + 37;
  localparam int GSW   = TB + 23;
  localparam int DNW   = ((TB > C_BITS) ? TB : C_BITS) + 2;
  localparam int FS    = 31 - LOG_TABLE_BITS;
  localparam logic [31:0]   LOG_FULL = log2_q16_const(FULL_RH, LOG_TABLE_BITS);
  localparam logic [NW-1:0] Q_MAX    = NW'((64'd1 << (TB - 1)) - 64'd1);
  localparam logic [NW-1:0] Q_MINMAG = NW'(64'd1 << (TB - 1));
  localparam logic signed [TB-1:0] T_MAX = {1'b0, {(TB-1){1'b1}}};
  localparam logic signed [TB-1:0] T_MIN = {1'b1, {(TB-1){1'b0}}};

  // Configuration registers
  logic [B_BITS-1:0] cfg_b;
  logic [C_BITS-1:0] cfg_c;

  // Sequencer
  state_t state;
  state_t state_next;
  logic   issued;

  // Captured sample
  logic [RH_BITS-1:0]   rh_r;
  logic signed [TB-1:0] th_r;
  logic signed [TB-1:0] tf_r;
  logic                 ok_r;
  logic                 dry_r;
  logic [TB-1:0]        th_mag;

  // Intermediate values
  logic [20:0]           lg_mag;
  logic                  lg_neg;
  logic signed [21:0]    ln_term;
  logic [DNW-2:0]        den;
  logic [GSW-1:0]        gamma_mag;
  logic                  gamma_neg;
  logic [GSW-1:0]        dden;
  logic [NW-1:0]         num;

  // Alarm state
  logic signed [TB-1:0] last_dp;
  logic                 in_range;

  // Output register
  logic                 out_valid;
  logic signed [TB-1:0] out_dp;
  logic                 out_ok;
  logic                 out_below;
  logic                 out_above;
  logic                 out_flag;
  logic                 out_dry;
  logic                 out_free;

  // Log front end
  logic [3:0]    log_e;
  logic [15:0]   log_t0;
  logic [16:0]   log_d;
  logic [FS-1:0] log_rem;

  // Shared unit
  mdu_ctl_t      mdu_ctl;
  logic [NW-1:0] mdu_a;
  logic [NW-1:0] mdu_b;
  logic          mdu_done;
  logic [NW-1:0] mdu_res;

  // Combinational results taken when a step finishes
  logic signed [21:0]    lg_c;
  logic [20:0]           ln_mag;
  logic signed [DNW-1:0] den_c;
  logic signed [GSW-1:0] frac_c;
  logic signed [GSW-1:0] gamma_c;
  logic signed [GSW:0]   dden_c;
  logic                  dden_bad;

  dpca_log #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_log (
    .rh (rh_r),
    .e  (log_e),
    .t0 (log_t0),
    .d  (log_d),
    .rem(log_rem)
  );

  dpca_mdu #(
    .NW(NW)
  ) u_mdu (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mdu_ctl),
    .opa   (mdu_a),
    .opb   (mdu_b),
    .done  (mdu_done),
    .result(mdu_res)
  );

  assign th_mag   = th_r[TB-1] ? TB'(-th_r) : TB'(th_r);
  assign out_free = !out_valid || m_tready;

  // Arithmetic taken at the end of each step
  always_comb begin
    lg_c = $signed(22'({log_e, 16'b0})) + $signed(22'(log_t0))
         + $signed(22'(mdu_res >> FS)) - $signed(22'(LOG_FULL));
    ln_mag  = 21'((mdu_res + NW'(32768)) >> 16);
    den_c   = $signed(DNW'(cfg_c)) + DNW'(th_r);
    frac_c  = th_r[TB-1] ? -$signed(GSW'(mdu_res)) : $signed(GSW'(mdu_res));
    gamma_c = GSW'(ln_term) + frac_c;
    dden_c  = $signed((GSW+1)'({cfg_b, 6'b0})) - (GSW+1)'(gamma_c);
    dden_bad = dden_c[GSW] || (dden_c == '0);
  end

  // Next state and commands to the shared unit
  always_comb begin
    state_next  = state;
    mdu_ctl.start = 1'b0;
    mdu_ctl.op    = OP_MUL;
    mdu_a = '0;
    mdu_b = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser && (s_tdata[RH_BITS-1:0] != '0)) begin
            state_next = ST_LOG_MUL;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_LOG_MUL: begin
        mdu_ctl.start = !issued;
        mdu_a = NW'(log_rem);
        mdu_b = NW'(log_d);
        if (mdu_done) begin
          state_next = ST_LN_MUL;
        end
      end
      ST_LN_MUL: begin
        mdu_ctl.start = !issued;
        mdu_a = NW'(lg_mag);
        mdu_b = NW'(LN2_Q16);
        if (mdu_done) begin
          state_next = ST_FR_MUL;
        end
      end
      ST_FR_MUL: begin
        mdu_ctl.start = !issued;
        mdu_a = NW'(cfg_b);
        mdu_b = NW'(th_mag);
        if (mdu_done) begin
          state_next = ST_FR_DIV;
        end
      end
      ST_FR_DIV: begin
        mdu_ctl.start = !issued;
        mdu_ctl.op    = OP_DIV;
        mdu_a = num;
        mdu_b = NW'(den);
        if (mdu_done) begin
          state_next = dden_bad ? ST_OUT : ST_DP_MUL;
        end
      end
      ST_DP_MUL: begin
        mdu_ctl.start = !issued;
        mdu_a = NW'(gamma_mag);
        mdu_b = NW'(cfg_c);
        if (mdu_done) begin
          state_next = ST_DP_DIV;
        end
      end
      ST_DP_DIV: begin
        mdu_ctl.start = !issued;
        mdu_ctl.op    = OP_DIV;
        mdu_a = num;
        mdu_b = NW'(dden);
        if (mdu_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // State register and command handshake with the shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mdu_done) begin
        issued <= 1'b0;
      end else if (mdu_ctl.start) begin
        issued <= 1'b1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_b <= B_RESET;
      cfg_c <= C_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAGNUS_B: cfg_b <= cfg_wdata;
        CFG_MAGNUS_C: cfg_c <= cfg_wdata[C_BITS-1:0];
      endcase
    end
  end

  // Datapath registers, updated as each step completes
  always_ff @(posedge clk) begin
    if (rst) begin
      last_dp <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rh_r  <= s_tdata[RH_BITS-1:0];
            th_r  <= s_tdata[RH_BITS+TB-1:RH_BITS];
            tf_r  <= s_tdata[RH_BITS+2*TB-1:RH_BITS+TB];
            ok_r  <= s_tuser;
            dry_r <= s_tuser && (s_tdata[RH_BITS-1:0] == '0);
            if (s_tuser && (s_tdata[RH_BITS-1:0] == '0)) begin
              last_dp <= T_MIN;
            end
          end
        end
        ST_LOG_MUL: begin
          if (mdu_done) begin
            lg_neg <= lg_c[21];
            lg_mag <= lg_c[21] ? 21'(-lg_c) : 21'(lg_c);
          end
        end
        ST_LN_MUL: begin
          if (mdu_done) begin
            ln_term <= lg_neg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
            den     <= (den_c[DNW-1] || den_c == '0) ? (DNW-1)'(1) : (DNW-1)'(den_c);
          end
        end
        ST_FR_MUL: begin
          if (mdu_done) begin
            num <= (mdu_res << 6) + NW'(den >> 1);
          end
        end
        ST_FR_DIV: begin
          if (mdu_done) begin
            gamma_neg <= gamma_c[GSW-1];
            gamma_mag <= gamma_c[GSW-1] ? GSW'(-gamma_c) : GSW'(gamma_c);
            dden      <= GSW'(dden_c);
            if (dden_bad) begin
              last_dp <= T_MAX;
            end
          end
        end
        ST_DP_MUL: begin
          if (mdu_done) begin
            num <= mdu_res + NW'(dden >> 1);
          end
        end
        ST_DP_DIV: begin
          if (mdu_done) begin
            if (gamma_neg) begin
              last_dp <= (mdu_res > Q_MINMAG) ? T_MIN : TB'(-mdu_res);
            end else begin
              last_dp <= (mdu_res > Q_MAX) ? T_MAX : TB'(mdu_res);
            end
          end
        end
        ST_OUT: begin
        end
      endcase
    end
  end

  // Threshold comparison and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_range  <= 1'b0;
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
      out_dp    <= last_dp;
      out_ok    <= ok_r;
      out_dry   <= dry_r;
      if (tf_r < last_dp) begin
        out_below <= in_range;
        out_above <= 1'b0;
        out_flag  <= 1'b0;
        in_range  <= 1'b0;
      end else begin
        out_below <= 1'b0;
        out_above <= !in_range;
        out_flag  <= 1'b1;
        in_range  <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_flag, out_above, out_below, out_dp});
  assign m_tuser  = {out_dry, out_ok};

  // The shared unit only finishes while the sequencer waits on it
  a_done_in_step : assert property (@(posedge clk) disable iff (rst)
    mdu_done |-> (state != ST_IDLE && state != ST_OUT))
    else $error("shared unit finished outside an arithmetic step");

  // An accepted item blocks the input for at least the following cycle
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in a row");

  // A dry sample always reports the minimum dew point
  a_dry_min : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_dry) |-> (out_dp == T_MIN))
    else $error("dry sample without minimum dew point");

  // A rising event always leaves the finger marked above the dew point
  a_above_flag : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_above) |-> (out_flag && !out_below))
    else $error("above event inconsistent with flags");

endmodule

// ----- sv/dpca_log.sv -----
// Log2 front end: normalises the humidity and looks up the interpolation table.
module dpca_log
  import dpca_pkg::*;
#(
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic [RH_BITS-1:0]          rh,
  output logic [3:0]                  e,
  output logic [15:0]                 t0,
  output logic [16:0]                 d,
  output logic [30-LOG_TABLE_BITS:0]  rem
);

  localparam int FS  = 31 - LOG_TABLE_BITS;
  localparam int TAB = 1 << LOG_TABLE_BITS;

  logic [16:0]             tab [TAB+1];
  logic [RH_BITS-1:0]      xn;
  logic [30:0]             frac;
  logic [LOG_TABLE_BITS:0] k_lo;
  logic [LOG_TABLE_BITS:0] k_hi;
  logic [16:0]             t0_w;
  logic [16:0]             t1_w;

  // Constant table, worked out at elaboration
  for (genvar g = 0; g <= TAB; g++) begin : g_tab
    assign tab[g] = log_entry(g, LOG_TABLE_BITS);
  end

  // Position of the leading one gives the integer part of the logarithm
  always_comb begin
    e = '0;
    for (int i = 0; i < RH_BITS; i++) begin
      if (rh[i]) begin
        e = 4'(i);
      end
    end
  end

  // Fraction below the leading one, split into table index and remainder
  always_comb begin
    xn   = rh << (4'(RH_BITS - 1) - e);
    frac = {xn[RH_BITS-2:0], {(31-(RH_BITS-1)){1'b0}}};
    k_lo = {1'b0, frac[30:FS]};
    k_hi = k_lo + 1'b1;
    rem  = frac[FS-1:0];
    t0_w = tab[k_lo];
    t1_w = tab[k_hi];
    t0   = t0_w[15:0];
    d    = (t1_w > t0_w) ? (t1_w - t0_w) : '0;
  end

endmodule

// ----- sv/dpca_mdu.sv -----
// Bit-serial multiply and restoring divide sharing one adder.
module dpca_mdu
  import dpca_pkg::*;
#(
  parameter int NW = 49
) (
  input  logic          clk,
  input  logic          rst,
  input  mdu_ctl_t      ctl,
  input  logic [NW-1:0] opa,
  input  logic [NW-1:0] opb,
  output logic          done,
  output logic [NW-1:0] result
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc;
  logic [NW-1:0] opnd;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          is_div;

  logic [NW:0]   x;
  logic [NW:0]   y;
  logic [NW+1:0] s;
  logic          carry;

  // One shared adder: add for multiply, subtract for divide
  always_comb begin
    x     = {acc, is_div ? opnd[NW-1] : 1'b0};
    y     = (is_div || opnd[NW-1]) ? {1'b0, dvs} : '0;
    s     = {1'b0, x} + {1'b0, is_div ? ~y : y} + (NW+2)'(is_div);
    carry = s[NW+1];
  end

  // Iteration: one multiplier bit or one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        acc <= '0;
        if (ctl.op == OP_DIV) begin
          is_div <= 1'b1;
          opnd   <= opa;
          dvs    <= opb;
          cnt    <= CW'(NW);
        end else begin
          is_div <= 1'b0;
          opnd   <= {opb[MUL_BITS-1:0], {(NW-MUL_BITS){1'b0}}};
          dvs    <= opa;
          cnt    <= CW'(MUL_BITS);
        end
      end else if (cnt != '0) begin
        if (is_div) begin
          acc <= carry ? s[NW-1:0] : x[NW-1:0];
        end else begin
          acc <= s[NW-1:0];
        end
        opnd <= {opnd[NW-2:0], is_div & carry};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  assign result = is_div ? opnd : acc;

endmodule
